FILE: src/jdq_pkg.sv
// jdq_pkg: shared types and constants for the joystick direction qualifier
// no dependencies; used by every other file of the block

package jdq_pkg;

  localparam int THR_W      = 12;
  localparam int STABLE_W   = 8;
  localparam int BTN_W      = 8;
  localparam int COLOR_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LED_EN    = 2'd2;

  localparam logic [THR_W-1:0]    THRESHOLD_RST = 12'd1800;
  localparam logic [STABLE_W-1:0] STABLE_RST    = 8'd3;
  localparam logic                LED_EN_RST    = 1'b1;

  localparam logic [COLOR_W-1:0] COLOR_BLUE  = 24'h0000FF;
  localparam logic [COLOR_W-1:0] COLOR_RED   = 24'hFF0000;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_e;

  typedef enum logic [1:0] {
    BTN_NONE     = 2'd0,
    BTN_PRESSED  = 2'd1,
    BTN_RELEASED = 2'd2
  } btn_evt_e;

  typedef struct packed {
    logic [THR_W-1:0]    threshold;
    logic [STABLE_W-1:0] stable;
    logic                led_en;
  } cfg_t;

  typedef struct packed {
    logic               dir_event;
    dir_e               dir_code;
    btn_evt_e           button_event;
    logic               button_down;
    logic               led_write;
    logic [COLOR_W-1:0] led_color;
  } res_t;

endpackage

FILE: src/jdq_if.sv
// jdq_if: valid/ready channel interfaces for input items and result items
// depends on jdq_pkg for field widths

interface jdq_in_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] axis_x;
  logic signed [SAMPLE_BITS-1:0] axis_y;
  logic [jdq_pkg::BTN_W-1:0]     button_raw;

  modport source (output valid, output axis_x, output axis_y, output button_raw,
                  input ready);
  modport sink (input valid, input axis_x, input axis_y, input button_raw,
                output ready);
endinterface

interface jdq_out_if ();
  logic                        valid;
  logic                        ready;
  logic                        dir_event;
  logic [2:0]                  dir_code;
  logic [1:0]                  button_event;
  logic                        button_down;
  logic                        led_write;
  logic [jdq_pkg::COLOR_W-1:0] led_color;

  modport source (output valid, output dir_event, output dir_code,
                  output button_event, output button_down, output led_write,
                  output led_color, input ready);
  modport sink (input valid, input dir_event, input dir_code,
                input button_event, input button_down, input led_write,
                input led_color, output ready);
endinterface

FILE: src/jdq_classify.sv
// jdq_classify: four-way direction decision from signed x/y offsets
// depends on jdq_pkg for the direction codes and threshold width

module jdq_classify #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic signed [SAMPLE_BITS-1:0]  axis_x_i,
  input  logic signed [SAMPLE_BITS-1:0]  axis_y_i,
  input  logic [jdq_pkg::THR_W-1:0]      threshold_i,
  output jdq_pkg::dir_e                  dir_o
);

  localparam int MW = (SAMPLE_BITS > jdq_pkg::THR_W) ? SAMPLE_BITS : jdq_pkg::THR_W;
  localparam int PW = SAMPLE_BITS + 2;

  logic                   neg_x, neg_y;
  logic [SAMPLE_BITS-1:0] mag_x, mag_y;
  logic [MW-1:0]          mag_x_w, mag_y_w, thr_w;
  logic [PW-1:0]          twice_x, twice_y, thrice_x, thrice_y;
  logic                   centred;

  always_comb begin
    neg_x    = axis_x_i[SAMPLE_BITS-1];
    neg_y    = axis_y_i[SAMPLE_BITS-1];
    mag_x    = neg_x ? ('0 - SAMPLE_BITS'(axis_x_i)) : SAMPLE_BITS'(axis_x_i);
    mag_y    = neg_y ? ('0 - SAMPLE_BITS'(axis_y_i)) : SAMPLE_BITS'(axis_y_i);
    mag_x_w  = MW'(mag_x);
    mag_y_w  = MW'(mag_y);
    thr_w    = MW'(threshold_i);
    twice_x  = PW'({mag_x, 1'b0});
    twice_y  = PW'({mag_y, 1'b0});
    thrice_x = twice_x + PW'(mag_x);
    thrice_y = twice_y + PW'(mag_y);
    centred  = (mag_x_w < thr_w) && (mag_y_w < thr_w);

    if (centred) begin
      dir_o = jdq_pkg::DIR_NONE;
    end else if (twice_y > thrice_x) begin
      dir_o = neg_y ? jdq_pkg::DIR_UP : jdq_pkg::DIR_DOWN;
    end else if (twice_x > thrice_y) begin
      dir_o = neg_x ? jdq_pkg::DIR_LEFT : jdq_pkg::DIR_RIGHT;
    end else begin
      dir_o = jdq_pkg::DIR_NONE;
    end
  end

endmodule

FILE: src/jdq_tracker.sv
// jdq_tracker: run counter, reported direction, button edges and led write
// depends on jdq_pkg; holds the block state and the result register

module jdq_tracker #(
  parameter int COUNT_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  jdq_pkg::dir_e              dir_i,
  input  logic [jdq_pkg::BTN_W-1:0]  button_raw_i,
  input  jdq_pkg::cfg_t              cfg_i,
  output jdq_pkg::res_t              res_o
);

  localparam int                  SW        = (COUNT_BITS > jdq_pkg::STABLE_W) ?
                                              COUNT_BITS : jdq_pkg::STABLE_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  jdq_pkg::dir_e           cand_q, cand_d, rep_q, rep_d;
  logic [COUNT_BITS-1:0]   run_q, run_d;
  logic                    btn_q, btn_d;
  jdq_pkg::res_t           res_q, res_d;
  logic                    pressed, stable_ok;

  always_comb begin
    pressed = (button_raw_i == '0);
    cand_d  = dir_i;
    rep_d   = rep_q;
    btn_d   = btn_q;
    res_d   = '0;

    if (dir_i == cand_q) begin
      run_d = (run_q == COUNT_MAX) ? run_q : run_q + 1'b1;
    end else begin
      run_d = '0;
    end
    stable_ok = SW'(run_d) >= SW'(cfg_i.stable);

    if (stable_ok && dir_i != jdq_pkg::DIR_NONE && dir_i != rep_q) begin
      res_d.dir_event = 1'b1;
      res_d.led_write = 1'b1;
      res_d.led_color = cfg_i.led_en ? jdq_pkg::COLOR_BLUE : jdq_pkg::COLOR_BLACK;
      rep_d           = dir_i;
    end else if (dir_i == jdq_pkg::DIR_NONE) begin
      res_d.led_write = 1'b1;
      res_d.led_color = jdq_pkg::COLOR_BLACK;
      rep_d           = jdq_pkg::DIR_NONE;
    end

    res_d.button_event = jdq_pkg::BTN_NONE;
    if (pressed && !btn_q) begin
      res_d.button_event = jdq_pkg::BTN_PRESSED;
      res_d.led_write    = 1'b1;
      res_d.led_color    = cfg_i.led_en ? jdq_pkg::COLOR_RED : jdq_pkg::COLOR_BLACK;
      btn_d              = 1'b1;
    end else if (!pressed && btn_q) begin
      res_d.button_event = jdq_pkg::BTN_RELEASED;
      res_d.led_write    = 1'b1;
      res_d.led_color    = jdq_pkg::COLOR_BLACK;
      btn_d              = 1'b0;
    end

    res_d.dir_code    = rep_d;
    res_d.button_down = btn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= jdq_pkg::DIR_NONE;
      run_q  <= '0;
      rep_q  <= jdq_pkg::DIR_NONE;
      btn_q  <= 1'b0;
      res_q  <= '0;
    end else if (load_i) begin
      cand_q <= cand_d;
      run_q  <= run_d;
      rep_q  <= rep_d;
      btn_q  <= btn_d;
      res_q  <= res_d;
    end
  end

  assign res_o = res_q;

`ifndef SYNTHESIS
  a_dir_event_writes_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.dir_event |-> res_q.led_write && res_q.dir_code != jdq_pkg::DIR_NONE)
    else $error("direction item without led write or with no direction");

  a_color_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_q.led_write |-> res_q.led_color == jdq_pkg::COLOR_BLACK)
    else $error("led color set without a write");

  a_press_sets_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (res_q.button_event == jdq_pkg::BTN_PRESSED) == ($rose(btn_q)))
    else $error("press item does not match button state change");

  a_disabled_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && !cfg_i.led_en |=> res_q.led_color == jdq_pkg::COLOR_BLACK)
    else $error("color passed while led disabled");

  a_report_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(load_i) |-> res_q.dir_code == rep_q && res_q.button_down == btn_q)
    else $error("result does not match held state");
`endif

endmodule

FILE: src/joystick_direction_qualifier_unit.sv
// joystick_direction_qualifier_unit: top level with input register, config
// registers and result handshake; depends on jdq_pkg, jdq_if, jdq_classify, jdq_tracker
// an accepted item is held in the input register, then its result goes to the tracker result register
// throughput: one item per cycle while the receiver is ready, limited by the single compute stage
// the input register, when empty, takes a new item while a finished result waits
// reset: state cleared, direction none, button released, config registers to defaults

module joystick_direction_qualifier_unit #(
  parameter int SAMPLE_BITS = 12,
  parameter int COUNT_BITS  = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  jdq_in_if.sink                          in_i,
  jdq_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [jdq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [jdq_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic                          in_valid_q, out_valid_q, advance, in_take;
  logic signed [SAMPLE_BITS-1:0] x_q, y_q;
  logic [jdq_pkg::BTN_W-1:0]     btn_q;
  jdq_pkg::cfg_t                 cfg_q;
  jdq_pkg::dir_e                 dir;
  jdq_pkg::res_t                 res;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_q   <= in_i.axis_x;
      y_q   <= in_i.axis_y;
      btn_q <= in_i.button_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= jdq_pkg::THRESHOLD_RST;
      cfg_q.stable    <= jdq_pkg::STABLE_RST;
      cfg_q.led_en    <= jdq_pkg::LED_EN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jdq_pkg::REG_THRESHOLD: cfg_q.threshold <= cfg_data_i[jdq_pkg::THR_W-1:0];
        jdq_pkg::REG_STABLE:    cfg_q.stable    <= cfg_data_i[jdq_pkg::STABLE_W-1:0];
        jdq_pkg::REG_LED_EN:    cfg_q.led_en    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  jdq_classify #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_classify (
    .axis_x_i    (x_q),
    .axis_y_i    (y_q),
    .threshold_i (cfg_q.threshold),
    .dir_o       (dir)
  );

  jdq_tracker #(
    .COUNT_BITS(COUNT_BITS)
  ) u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance),
    .dir_i        (dir),
    .button_raw_i (btn_q),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.dir_event    = res.dir_event;
  assign out_o.dir_code     = res.dir_code;
  assign out_o.button_event = res.button_event;
  assign out_o.button_down  = res.button_down;
  assign out_o.led_write    = res.led_write;
  assign out_o.led_color    = res.led_color;

endmodule

FILE: tb/tb.sv
// tb: self-checking bench for joystick_direction_qualifier_unit
// needs jdq_pkg, jdq_if and the block; a scoreboard class predicts each result item
// phases cover default, extreme and random register settings, mostly under random idling

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 8;
  localparam int COUNT_MAX   = (1 << COUNT_BITS) - 1;
  localparam int MAG_MAX     = 1 << (SAMPLE_BITS - 1);
  localparam int LIMIT       = 300000;
  localparam int LONG_HOLD   = 300;

  class dir_led_predictor;
    logic [jdq_pkg::THR_W-1:0]    threshold   = jdq_pkg::THRESHOLD_RST;
    logic [jdq_pkg::STABLE_W-1:0] stable_need = jdq_pkg::STABLE_RST;
    logic                         led_en      = jdq_pkg::LED_EN_RST;
    jdq_pkg::dir_e                cand_dir    = jdq_pkg::DIR_NONE;
    int unsigned                  run_len     = 0;
    jdq_pkg::dir_e                shown_dir   = jdq_pkg::DIR_NONE;
    logic                         btn_held    = 1'b0;
    jdq_pkg::res_t                pending_results[$];
    int unsigned                  mismatches  = 0;
    int unsigned                  items_taken = 0;
    int unsigned                  dir_reports = 0;
    int unsigned                  btn_edges   = 0;

    function void write_reg(logic [jdq_pkg::CFG_IDX_W-1:0] idx,
                            logic [jdq_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        jdq_pkg::REG_THRESHOLD: threshold = data[jdq_pkg::THR_W-1:0];
        jdq_pkg::REG_STABLE:    stable_need = data[jdq_pkg::STABLE_W-1:0];
        jdq_pkg::REG_LED_EN:    led_en = data[0];
        default: ;
      endcase
    endfunction

    function jdq_pkg::dir_e sort_dir(logic signed [SAMPLE_BITS-1:0] x,
                                     logic signed [SAMPLE_BITS-1:0] y);
      int ax;
      int ay;
      ax = int'(x);
      ay = int'(y);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      if (ax < int'(threshold) && ay < int'(threshold)) return jdq_pkg::DIR_NONE;
      if (2 * ay > 3 * ax) return (y < 0) ? jdq_pkg::DIR_UP : jdq_pkg::DIR_DOWN;
      if (2 * ax > 3 * ay) return (x < 0) ? jdq_pkg::DIR_LEFT : jdq_pkg::DIR_RIGHT;
      return jdq_pkg::DIR_NONE;
    endfunction

    function void take_sample(logic signed [SAMPLE_BITS-1:0] x,
                              logic signed [SAMPLE_BITS-1:0] y,
                              logic [jdq_pkg::BTN_W-1:0] b);
      jdq_pkg::dir_e cur;
      jdq_pkg::res_t r;
      logic pressed;
      cur = sort_dir(x, y);
      r = '0;
      pressed = (b == '0);
      items_taken++;
      if (cur == cand_dir) begin
        if (run_len < COUNT_MAX) run_len++;
      end else begin
        run_len = 0;
        cand_dir = cur;
      end
      if (run_len >= stable_need && cur != jdq_pkg::DIR_NONE && cur != shown_dir) begin
        r.dir_event = 1'b1;
        r.led_write = 1'b1;
        r.led_color = led_en ? jdq_pkg::COLOR_BLUE : jdq_pkg::COLOR_BLACK;
        shown_dir = cur;
        dir_reports++;
      end else if (cur == jdq_pkg::DIR_NONE) begin
        r.led_write = 1'b1;
        r.led_color = jdq_pkg::COLOR_BLACK;
        shown_dir = jdq_pkg::DIR_NONE;
      end
      if (pressed && !btn_held) begin
        r.button_event = jdq_pkg::BTN_PRESSED;
        r.led_write = 1'b1;
        r.led_color = led_en ? jdq_pkg::COLOR_RED : jdq_pkg::COLOR_BLACK;
        btn_held = 1'b1;
        btn_edges++;
      end else if (!pressed && btn_held) begin
        r.button_event = jdq_pkg::BTN_RELEASED;
        r.led_write = 1'b1;
        r.led_color = jdq_pkg::COLOR_BLACK;
        btn_held = 1'b0;
        btn_edges++;
      end
      r.dir_code = shown_dir;
      r.button_down = btn_held;
      pending_results.push_back(r);
    endfunction

    function void check_field(string name, logic [jdq_pkg::COLOR_W-1:0] want,
                              logic [jdq_pkg::COLOR_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(jdq_pkg::res_t got);
      jdq_pkg::res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result item with none expected, actual %0h", $time, got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      check_field("dir_event", jdq_pkg::COLOR_W'(want.dir_event),
                  jdq_pkg::COLOR_W'(got.dir_event));
      check_field("dir_code", jdq_pkg::COLOR_W'(want.dir_code),
                  jdq_pkg::COLOR_W'(got.dir_code));
      check_field("button_event", jdq_pkg::COLOR_W'(want.button_event),
                  jdq_pkg::COLOR_W'(got.button_event));
      check_field("button_down", jdq_pkg::COLOR_W'(want.button_down),
                  jdq_pkg::COLOR_W'(got.button_down));
      check_field("led_write", jdq_pkg::COLOR_W'(want.led_write),
                  jdq_pkg::COLOR_W'(got.led_write));
      check_field("led_color", want.led_color, got.led_color);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [jdq_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [jdq_pkg::CFG_DATA_W-1:0] cfg_data_i;

  jdq_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  jdq_out_if out_ch ();

  joystick_direction_qualifier_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  dir_led_predictor sb;
  int unsigned max_gap = 12;
  bit long_hold = 1'b0;
  bit held_btn = 1'b0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.axis_x = '0;
    in_ch.axis_y = '0;
    in_ch.button_raw = '1;
    out_ch.ready = 1'b0;
  end

  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_item(input logic signed [SAMPLE_BITS-1:0] x,
                           input logic signed [SAMPLE_BITS-1:0] y,
                           input logic [jdq_pkg::BTN_W-1:0] b);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.axis_x <= x;
    in_ch.axis_y <= y;
    in_ch.button_raw <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.take_sample(x, y, b);
  endtask

  task automatic collect_results();
    int unsigned gap;
    jdq_pkg::res_t got;
    forever begin
      gap = $urandom_range(0, max_gap);
      if (long_hold) begin
        gap = LONG_HOLD;
        long_hold = 1'b0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      got.dir_event = out_ch.dir_event;
      got.dir_code = jdq_pkg::dir_e'(out_ch.dir_code);
      got.button_event = jdq_pkg::btn_evt_e'(out_ch.button_event);
      got.button_down = out_ch.button_down;
      got.led_write = out_ch.led_write;
      got.led_color = out_ch.led_color;
      sb.match_result(got);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(input int thr, input int stable, input int led);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= jdq_pkg::REG_THRESHOLD;
    cfg_data_i <= jdq_pkg::CFG_DATA_W'(thr);
    @(posedge clk_i);
    sb.write_reg(jdq_pkg::REG_THRESHOLD, jdq_pkg::CFG_DATA_W'(thr));
    cfg_idx_i <= jdq_pkg::REG_STABLE;
    cfg_data_i <= jdq_pkg::CFG_DATA_W'(stable);
    @(posedge clk_i);
    sb.write_reg(jdq_pkg::REG_STABLE, jdq_pkg::CFG_DATA_W'(stable));
    cfg_idx_i <= jdq_pkg::REG_LED_EN;
    cfg_data_i <= jdq_pkg::CFG_DATA_W'(led);
    @(posedge clk_i);
    sb.write_reg(jdq_pkg::REG_LED_EN, jdq_pkg::CFG_DATA_W'(led));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // sample meant to sort into d under threshold thr, with random content; it reads as none if thr is beyond reach
  task automatic make_point(input jdq_pkg::dir_e d, input int thr,
                            output logic signed [SAMPLE_BITS-1:0] x,
                            output logic signed [SAMPLE_BITS-1:0] y);
    int m;
    int n;
    int lo;
    bit neg;
    lo = (thr > MAG_MAX) ? MAG_MAX : thr;
    neg = (d == jdq_pkg::DIR_UP || d == jdq_pkg::DIR_LEFT);
    if (d == jdq_pkg::DIR_NONE) begin
      if (thr > 0 && $urandom_range(0, 1)) begin
        m = $urandom_range(0, (thr - 1 > MAG_MAX - 1) ? MAG_MAX - 1 : thr - 1);
        n = $urandom_range(0, (thr - 1 > MAG_MAX - 1) ? MAG_MAX - 1 : thr - 1);
      end else begin
        m = $urandom_range(0, MAG_MAX - 1);
        n = m;
      end
      x = SAMPLE_BITS'($urandom_range(0, 1) ? -m : m);
      y = SAMPLE_BITS'($urandom_range(0, 1) ? -n : n);
    end else begin
      m = $urandom_range(lo, MAG_MAX);
      if (!neg && m > MAG_MAX - 1) m = MAG_MAX - 1;
      n = $urandom_range(0, (2 * m - 1) / 3);
      if ($urandom_range(0, 1)) n = -n;
      if (neg) m = -m;
      if (d == jdq_pkg::DIR_UP || d == jdq_pkg::DIR_DOWN) begin
        y = SAMPLE_BITS'(m);
        x = SAMPLE_BITS'(n);
      end else begin
        x = SAMPLE_BITS'(m);
        y = SAMPLE_BITS'(n);
      end
    end
  endtask

  function automatic logic [jdq_pkg::BTN_W-1:0] btn_value();
    return held_btn ? '0 : jdq_pkg::BTN_W'($urandom_range(1, 255));
  endfunction

  task automatic hold_run(input jdq_pkg::dir_e d, input int len);
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    repeat (len) begin
      if ($urandom_range(0, 11) == 0) held_btn = !held_btn;
      make_point(d, int'(sb.threshold), x, y);
      send_item(x, y, btn_value());
    end
  endtask

  task automatic random_items(input int count);
    int sent;
    int len;
    logic [jdq_pkg::BTN_W-1:0] b;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(1, 8);
        hold_run(jdq_pkg::dir_e'($urandom_range(0, 4)), len);
        sent += len;
      end else begin
        b = ($urandom_range(0, 3) == 0) ? '0 : jdq_pkg::BTN_W'($urandom());
        send_item(SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()), b);
        sent++;
      end
    end
  endtask

  task automatic directed_items();
    send_item(SAMPLE_BITS'(0), SAMPLE_BITS'(0), 8'hFF);
    repeat (5) send_item(SAMPLE_BITS'(0), SAMPLE_BITS'(-2048), 8'h01);
    repeat (3) send_item(SAMPLE_BITS'(5), SAMPLE_BITS'(2047), 8'h80);
    send_item(SAMPLE_BITS'(-5), SAMPLE_BITS'(2047), 8'h00);
    repeat (3) send_item(SAMPLE_BITS'(-2048), SAMPLE_BITS'(-1365), 8'h00);
    send_item(SAMPLE_BITS'(-2048), SAMPLE_BITS'(1365), 8'hFE);
    send_item(SAMPLE_BITS'(2047), SAMPLE_BITS'(0), 8'h00);
    repeat (2) send_item(SAMPLE_BITS'(2047), SAMPLE_BITS'(-1), 8'h00);
    send_item(SAMPLE_BITS'(2047), SAMPLE_BITS'(2047), 8'h7F);
    send_item(SAMPLE_BITS'(-2048), SAMPLE_BITS'(-2048), 8'h00);
    send_item(SAMPLE_BITS'(1799), SAMPLE_BITS'(-1799), 8'h00);
    send_item(SAMPLE_BITS'(1800), SAMPLE_BITS'(0), 8'hFF);
  endtask

  initial begin
    sb = new;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      collect_results();
    join_none

    // defaults after reset
    max_gap = 12;
    directed_items();
    random_items(200);
    drain();

    // widest window, immediate report, led off, no idling
    set_regs(0, 0, 0);
    max_gap = 0;
    random_items(200);
    drain();

    // nothing deflects, then a run long enough to saturate the counter
    set_regs(4095, 255, 1);
    max_gap = 12;
    random_items(60);
    drain();
    set_regs(1000, 255, 1);
    hold_run(jdq_pkg::DIR_LEFT, 258);
    random_items(40);
    drain();

    // receiver holds off while items keep coming
    set_regs($urandom_range(600, 1900), $urandom_range(1, 5), 1);
    max_gap = 3;
    long_hold = 1'b1;
    random_items(150);
    drain();

    set_regs($urandom_range(200, 2100), $urandom_range(0, 8), $urandom_range(0, 1));
    max_gap = 12;
    random_items(30);
    drain();
    repeat (10) @(posedge clk_i);

    $display("run covered %0d items over six register settings", sb.items_taken);
    $display("%0d direction reports and %0d button edges, %0d mismatches",
             sb.dir_reports, sb.btn_edges, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
